// ===== rtl/plr_pkg.sv =====
`default_nettype none
package plr_pkg;

  localparam int NUM_LAYERS = 24;
  localparam int IDX_W      = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  localparam int OP_W       = 2;
  localparam int LAYER_W    = 5;
  localparam int ENERGY_W   = 32;
  localparam int SUM_W      = 48;
  localparam int PROD_W     = 2 * ENERGY_W;
  localparam int QUO_W      = PROD_W - 1;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_SET_EXP = 2'd0,
    OP_ACCUM   = 2'd1,
    OP_SCALE   = 2'd2,
    OP_CLEAR   = 2'd3
  } plr_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ABS,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } plr_state_e;

  typedef struct packed {
    logic load;
    logic wr_exp;
    logic wr_sum;
    logic clear;
    logic bypass_res;
    logic mul;
    logic abs_init;
    logic div_step;
    logic finish;
    logic out_load;
  } plr_cmd_t;

  typedef struct packed {
    plr_op_e op;
    logic    bypass;
    logic    div_last;
    logic    out_free;
  } plr_stat_t;

endpackage
`default_nettype wire

// ===== rtl/plr_ctrl.sv =====
`default_nettype none
module plr_ctrl import plr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire plr_stat_t stat_i,
  output plr_cmd_t       cmd_o
);

  plr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat_i.op)
          OP_SET_EXP: begin
            cmd_o.wr_exp = 1'b1;
            state_d      = ST_IDLE;
          end
          OP_ACCUM: begin
            cmd_o.wr_sum = 1'b1;
            state_d      = ST_IDLE;
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
          OP_SCALE: begin
            if (stat_i.bypass) begin
              cmd_o.bypass_res = 1'b1;
              state_d          = ST_OUT;
            end else begin
              cmd_o.mul = 1'b1;
              state_d   = ST_ABS;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ABS: begin
        cmd_o.abs_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/plr_datapath.sv =====
`default_nettype none
module plr_datapath import plr_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire plr_cmd_t                   cmd_i,
  output plr_stat_t                       stat_o,
  input  wire logic [OP_W-1:0]            operation_i,
  input  wire logic [LAYER_W-1:0]         layer_i,
  input  wire logic signed [ENERGY_W-1:0] energy_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic signed [ENERGY_W-1:0]      scaled_energy_o,
  output logic [LAYER_W-1:0]              layer_out_o,
  output logic                            was_scaled_o,
  output logic                            saturated_o
);

  logic signed [SUM_W-1:0]    sum_q [NUM_LAYERS];
  logic signed [ENERGY_W-1:0] exp_q [NUM_LAYERS];

  plr_op_e                    op_q;
  logic [LAYER_W-1:0]         layer_q;
  logic signed [ENERGY_W-1:0] energy_q;

  logic signed [PROD_W-1:0]   prod_q;
  logic [SUM_W-1:0]           dvs_q;
  logic                       dvs_neg_q;
  logic [QUO_W-1:0]           dvd_q;
  logic [SUM_W-1:0]           rem_q;
  logic                       neg_q;
  logic [CNT_W-1:0]           cnt_q;

  logic signed [ENERGY_W-1:0] res_val_q;
  logic                       res_scaled_q;
  logic                       res_sat_q;

  logic                       out_valid_q;
  logic signed [ENERGY_W-1:0] out_val_q;
  logic [LAYER_W-1:0]         out_layer_q;
  logic                       out_scaled_q;
  logic                       out_sat_q;

  logic                       layer_ok;
  logic [IDX_W-1:0]           idx;
  logic signed [SUM_W-1:0]    sum_rd;
  logic signed [ENERGY_W-1:0] exp_rd;
  logic signed [SUM_W:0]      acc_full;
  logic signed [SUM_W-1:0]    acc_sat;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [PROD_W-1:0]   prod_neg;
  logic [SUM_W-1:0]           sum_abs;
  logic [SUM_W:0]             shifted;
  logic [SUM_W:0]             diff;
  logic                       q_bit;
  logic                       fin_sat;
  logic [ENERGY_W-1:0]        fin_mag;
  logic signed [ENERGY_W-1:0] fin_val;
  logic                       out_free;

  assign layer_ok = (int'(layer_q) < NUM_LAYERS);
  assign idx      = IDX_W'(layer_q);
  assign sum_rd   = layer_ok ? sum_q[idx] : '0;
  assign exp_rd   = layer_ok ? exp_q[idx] : '0;

  assign acc_full = {sum_rd[SUM_W-1], sum_rd} + (SUM_W+1)'(energy_q);
  always_comb begin
    if (acc_full[SUM_W] != acc_full[SUM_W-1]) begin
      acc_sat = acc_full[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_full[SUM_W-1:0];
    end
  end

  assign prod_full = energy_q * exp_rd;
  assign sum_abs   = sum_rd[SUM_W-1] ? SUM_W'(-sum_rd) : sum_rd;
  assign prod_neg  = -prod_q;

  assign shifted = {rem_q, dvd_q[QUO_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign q_bit   = (shifted >= {1'b0, dvs_q});

  always_comb begin
    if (neg_q) begin
      fin_sat = (dvd_q[QUO_W-1:ENERGY_W] != '0) ||
                (dvd_q[ENERGY_W-1] && (dvd_q[ENERGY_W-2:0] != '0));
    end else begin
      fin_sat = (dvd_q[QUO_W-1:ENERGY_W-1] != '0);
    end
    fin_mag = dvd_q[ENERGY_W-1:0];
    if (fin_sat) begin
      fin_val = neg_q ? {1'b1, {(ENERGY_W-1){1'b0}}} : {1'b0, {(ENERGY_W-1){1'b1}}};
    end else begin
      fin_val = neg_q ? -$signed(fin_mag) : $signed(fin_mag);
    end
  end

  assign out_free        = !out_valid_q || out_ready_i;
  assign stat_o.op       = op_q;
  assign stat_o.bypass   = !layer_ok || (sum_rd == '0);
  assign stat_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        sum_q[i] <= '0;
        exp_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        sum_q[i] <= '0;
        exp_q[i] <= '0;
      end
    end else begin
      if (cmd_i.wr_exp && layer_ok) begin
        exp_q[idx] <= energy_q;
      end
      if (cmd_i.wr_sum && layer_ok) begin
        sum_q[idx] <= acc_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_SET_EXP;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        op_q <= plr_op_e'(operation_i);
      end
      if (cmd_i.abs_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      layer_q  <= layer_i;
      energy_q <= energy_i;
    end
    if (cmd_i.mul) begin
      prod_q    <= prod_full;
      dvs_q     <= sum_abs;
      dvs_neg_q <= sum_rd[SUM_W-1];
    end
    if (cmd_i.abs_init) begin
      dvd_q <= prod_q[PROD_W-1] ? prod_neg[QUO_W-1:0] : prod_q[QUO_W-1:0];
      neg_q <= prod_q[PROD_W-1] ^ dvs_neg_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      dvd_q <= {dvd_q[QUO_W-2:0], q_bit};
    end
    if (cmd_i.bypass_res) begin
      res_val_q    <= energy_q;
      res_scaled_q <= 1'b0;
      res_sat_q    <= 1'b0;
    end else if (cmd_i.finish) begin
      res_val_q    <= fin_val;
      res_scaled_q <= 1'b1;
      res_sat_q    <= fin_sat;
    end
    if (cmd_i.out_load) begin
      out_val_q    <= res_val_q;
      out_layer_q  <= layer_q;
      out_scaled_q <= res_scaled_q;
      out_sat_q    <= res_sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scaled_energy_o = out_val_q;
  assign layer_out_o     = out_layer_q;
  assign was_scaled_o    = out_scaled_q;
  assign saturated_o     = out_sat_q;

  a_sat_needs_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_sat_q || out_scaled_q))
    else $error("saturated result without scaling");

  a_scaled_layer_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scaled_q) |-> (int'(out_layer_q) < NUM_LAYERS))
    else $error("scaled result for a layer outside the tables");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)))
    else $error("divider ran past its last step");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (sum_q[0] == '0) && (exp_q[0] == '0))
    else $error("tables not cleared");

endmodule
`default_nettype wire

// ===== rtl/per_layer_energy_renormalizer.sv =====
// Per-layer energy renormalizer.
// Input channel (in_valid_i / in_ready_o) carries operation_i, layer_i and
// energy_i; a transfer happens when valid and ready are both high. Output
// channel (out_valid_o / out_ready_i) carries one result per scale request.
// Set-expected, accumulate and clear-all go from idle through the execute
// state and back to idle before the next transfer; they produce no result.
// Clear-all empties both layer tables at once.
// A scale request with a zero layer sum or a layer outside the table is
// registered as the result and then loaded into the output register. A
// scaled request goes through one 32x32 multiply, an absolute-value step, a
// 1-bit-per-cycle restoring divider on the 63-bit product magnitude, a sign
// and saturation step and the output load. The block takes no new request
// until the current one has been loaded into the output register.
// The output register holds a finished result while the next item is taken
// in; if the receiver stalls, a second result waits until the first is
// transferred, and input stays blocked meanwhile.
// Reset clears both tables, the controller and the output valid.
`default_nettype none
module per_layer_energy_renormalizer import plr_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [OP_W-1:0]            operation_i,
  input  wire logic [LAYER_W-1:0]         layer_i,
  input  wire logic signed [ENERGY_W-1:0] energy_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [ENERGY_W-1:0]      scaled_energy_o,
  output logic [LAYER_W-1:0]              layer_out_o,
  output logic                            was_scaled_o,
  output logic                            saturated_o
);

  plr_cmd_t  cmd;
  plr_stat_t stat;

  plr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  plr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .layer_i         (layer_i),
    .energy_i        (energy_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .scaled_energy_o (scaled_energy_o),
    .layer_out_o     (layer_out_o),
    .was_scaled_o    (was_scaled_o),
    .saturated_o     (saturated_o)
  );

endmodule
`default_nettype wire

// ===== verif/per_layer_energy_renormalizer_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module per_layer_energy_renormalizer_tb;
  import plr_pkg::*;

  localparam longint SUM_TOP  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_BOT  = -SUM_TOP - 64'sd1;
  localparam longint E_TOP    = 64'sd2147483647;
  localparam longint E_BOT    = -64'sd2147483648;
  localparam int     N_DIR    = 27;
  localparam int     N_RAND   = 1200;
  localparam int     N_BIGACC = 8;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic [LAYER_W-1:0]         layer;
    logic                       was_scaled;
    logic                       saturated;
  } scale_res_t;

  typedef struct packed {
    plr_op_e                    op;
    logic [LAYER_W-1:0]         layer;
    logic signed [ENERGY_W-1:0] energy;
    logic                       typed;
    scale_res_t                 want;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [OP_W-1:0]            operation_i = '0;
  logic [LAYER_W-1:0]         layer_i = '0;
  logic signed [ENERGY_W-1:0] energy_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [ENERGY_W-1:0] scaled_energy_o;
  logic [LAYER_W-1:0]         layer_out_o;
  logic                       was_scaled_o;
  logic                       saturated_o;

  logic signed [ENERGY_W-1:0] exp_kev [NUM_LAYERS];
  logic signed [SUM_W-1:0]    sum_kev [NUM_LAYERS];
  scale_res_t                 pending_scaled [$];
  scale_res_t                 got_res;
  scale_res_t                 want_res;
  stim_row_t                  dir_rows [N_DIR];
  int                         err_cnt = 0;
  int unsigned                stall_left = 0;
  int unsigned                stall_roll;
  bit                         quiet = 1'b0;

  per_layer_energy_renormalizer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .layer_i         (layer_i),
    .energy_i        (energy_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .scaled_energy_o (scaled_energy_o),
    .layer_out_o     (layer_out_o),
    .was_scaled_o    (was_scaled_o),
    .saturated_o     (saturated_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit renorm_predict(input plr_op_e op, input logic [LAYER_W-1:0] lay,
                                        input logic signed [ENERGY_W-1:0] e,
                                        output scale_res_t res);
    longint acc;
    longint prod;
    longint quo;
    bit     in_table;
    bit     has_res;
    in_table = lay < NUM_LAYERS;
    has_res = 1'b0;
    res = '0;
    case (op)
      OP_SET_EXP: begin
        if (in_table) exp_kev[lay] = e;
      end
      OP_ACCUM: begin
        if (in_table) begin
          acc = sum_kev[lay] + e;
          if (acc > SUM_TOP) acc = SUM_TOP;
          if (acc < SUM_BOT) acc = SUM_BOT;
          sum_kev[lay] = acc[SUM_W-1:0];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NUM_LAYERS; i++) begin
          exp_kev[i] = '0;
          sum_kev[i] = '0;
        end
      end
      default: begin
        has_res = 1'b1;
        res.energy = e;
        res.layer = lay;
        if (in_table && sum_kev[lay] != 0) begin
          prod = e * exp_kev[lay];
          quo = prod / sum_kev[lay];
          res.was_scaled = 1'b1;
          if (quo > E_TOP) begin
            quo = E_TOP;
            res.saturated = 1'b1;
          end else if (quo < E_BOT) begin
            quo = E_BOT;
            res.saturated = 1'b1;
          end
          res.energy = quo[ENERGY_W-1:0];
        end
      end
    endcase
    return has_res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ENERGY_W-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      4, 5, 6: return $urandom_range(0, 10000) - 5000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input plr_op_e op, input logic [LAYER_W-1:0] lay,
                           input logic [ENERGY_W-1:0] e, input bit typed,
                           input scale_res_t want);
    scale_res_t  pred;
    int unsigned gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    layer_i     <= lay;
    energy_i    <= e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (renorm_predict(op, lay, e, pred)) pending_scaled.push_back(typed ? want : pred);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 60) begin
        out_ready_i <= 1'b1;
      end else if (stall_roll < 95) begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(0, 3);
      end else begin
        out_ready_i <= 1'b0;
        stall_left  <= $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res = '{scaled_energy_o, layer_out_o, was_scaled_o, saturated_o};
      if (pending_scaled.size() == 0) begin
        $error("unexpected result: scaled_energy %0d layer_out %0d", scaled_energy_o,
               layer_out_o);
        err_cnt++;
      end else begin
        want_res = pending_scaled.pop_front();
        if (got_res.energy !== want_res.energy) begin
          $error("scaled_energy: expected %0d, actual %0d", want_res.energy, got_res.energy);
          err_cnt++;
        end
        if (got_res.layer !== want_res.layer) begin
          $error("layer_out: expected %0d, actual %0d", want_res.layer, got_res.layer);
          err_cnt++;
        end
        if (got_res.was_scaled !== want_res.was_scaled) begin
          $error("was_scaled: expected %0b, actual %0b", want_res.was_scaled,
                 got_res.was_scaled);
          err_cnt++;
        end
        if (got_res.saturated !== want_res.saturated) begin
          $error("saturated: expected %0b, actual %0b", want_res.saturated,
                 got_res.saturated);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #(64'd40_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned        roll;
    plr_op_e            op;
    logic [LAYER_W-1:0] lay;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      exp_kev[i] = '0;
      sum_kev[i] = '0;
    end
    dir_rows = '{
      '{OP_SCALE,   5'd0,  32'sd1234,     1'b1, '{32'sd1234,     5'd0,  1'b0, 1'b0}},
      '{OP_SCALE,   5'd31, -32'sd1,       1'b1, '{-32'sd1,       5'd31, 1'b0, 1'b0}},
      '{OP_SCALE,   5'd24, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 5'd24, 1'b0, 1'b0}},
      '{OP_SET_EXP, 5'd0,  32'sd1000,     1'b0, '0},
      '{OP_ACCUM,   5'd0,  32'sd500,      1'b0, '0},
      '{OP_SCALE,   5'd0,  32'sd7,        1'b1, '{32'sd14,       5'd0,  1'b1, 1'b0}},
      '{OP_SCALE,   5'd0,  -32'sd7,       1'b1, '{-32'sd14,      5'd0,  1'b1, 1'b0}},
      '{OP_SCALE,   5'd0,  32'sd0,        1'b1, '{32'sd0,        5'd0,  1'b1, 1'b0}},
      '{OP_SET_EXP, 5'd23, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_ACCUM,   5'd23, 32'sd1,        1'b0, '0},
      '{OP_SCALE,   5'd23, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 5'd23, 1'b1, 1'b1}},
      '{OP_SCALE,   5'd23, 32'h8000_0000, 1'b1, '{32'h8000_0000, 5'd23, 1'b1, 1'b1}},
      '{OP_SET_EXP, 5'd5,  32'h8000_0000, 1'b0, '0},
      '{OP_ACCUM,   5'd5,  32'h8000_0000, 1'b0, '0},
      '{OP_SCALE,   5'd5,  32'h8000_0000, 1'b1, '{32'h8000_0000, 5'd5,  1'b1, 1'b0}},
      '{OP_ACCUM,   5'd3,  32'sd5,        1'b0, '0},
      '{OP_ACCUM,   5'd3,  -32'sd5,       1'b0, '0},
      '{OP_SCALE,   5'd3,  32'sd99,       1'b1, '{32'sd99,       5'd3,  1'b0, 1'b0}},
      '{OP_SET_EXP, 5'd31, 32'sd77,       1'b0, '0},
      '{OP_ACCUM,   5'd31, 32'sd77,       1'b0, '0},
      '{OP_SCALE,   5'd12, -32'sd3,       1'b1, '{-32'sd3,       5'd12, 1'b0, 1'b0}},
      '{OP_ACCUM,   5'd12, 32'sd3,        1'b0, '0},
      '{OP_SCALE,   5'd12, -32'sd3,       1'b1, '{32'sd0,        5'd12, 1'b1, 1'b0}},
      '{OP_SET_EXP, 5'd1,  -32'sd300,     1'b0, '0},
      '{OP_ACCUM,   5'd1,  -32'sd7,       1'b0, '0},
      '{OP_SCALE,   5'd1,  32'sd1000,     1'b0, '0},
      '{OP_CLEAR,   5'd0,  32'sd0,        1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++)
      send_item(dir_rows[i].op, dir_rows[i].layer, dir_rows[i].energy, dir_rows[i].typed,
                dir_rows[i].want);
    send_item(OP_SCALE, 5'd0, 32'sd7, 1'b1, '{32'sd7, 5'd0, 1'b0, 1'b0});

    // push two layer sums far out with extreme cell energies, then step back
    quiet = 1'b1;
    send_item(OP_SET_EXP, 5'd7, 32'sd1 <<< 30, 1'b0, '0);
    send_item(OP_SET_EXP, 5'd8, -32'sd123456789, 1'b0, '0);
    for (int k = 0; k < N_BIGACC; k++) begin
      send_item(OP_ACCUM, 5'd7, 32'h7FFF_FFFF, 1'b0, '0);
      send_item(OP_ACCUM, 5'd8, 32'h8000_0000, 1'b0, '0);
    end
    quiet = 1'b0;
    send_item(OP_SCALE, 5'd7, 32'h7FFF_FFFF, 1'b0, '0);
    send_item(OP_SCALE, 5'd8, 32'h8000_0000, 1'b0, '0);
    send_item(OP_ACCUM, 5'd7, 32'h8000_0000, 1'b0, '0);
    send_item(OP_ACCUM, 5'd8, 32'h7FFF_FFFF, 1'b0, '0);
    send_item(OP_SCALE, 5'd7, -32'sd999999, 1'b0, '0);
    send_item(OP_SCALE, 5'd8, 32'sd999999, 1'b0, '0);

    for (int i = 0; i < N_RAND; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == N_RAND / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_scaled.size() != 0) @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) op = OP_SET_EXP;
      else if (roll < 60) op = OP_ACCUM;
      else if (roll < 98) op = OP_SCALE;
      else op = OP_CLEAR;
      lay = ($urandom_range(0, 9) == 0) ? LAYER_W'($urandom_range(24, 31)) :
                                          LAYER_W'($urandom_range(0, 23));
      send_item(op, lay, pick_energy(), 1'b0, '0);
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_scaled.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (err_cnt == 0 && pending_scaled.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/plr_pkg.sv
rtl/plr_ctrl.sv
rtl/plr_datapath.sv
rtl/per_layer_energy_renormalizer.sv
verif/per_layer_energy_renormalizer_tb.sv
